/* rtl/vrlr_pkg.sv */
// vrlr_pkg: shared types, sizes and helpers of the log record ring
package vrlr_pkg;

    // ring and record sizes
    localparam int RING_BYTES  = 1024;
    localparam int LINE_MAX    = 64;
    localparam int HDR_BYTES   = 2;
    localparam int MAX_LEN     = LINE_MAX - 1;

    // widths, some derived from the sizes
    localparam int POS_W       = $clog2(RING_BYTES);
    localparam int CNT_W       = $clog2(RING_BYTES + 1);
    localparam int LEN_W       = $clog2(LINE_MAX);
    localparam int REC_W       = 10;
    localparam int IDX_W       = 9;
    localparam int LIMIT_W     = 7;
    localparam int REQLEN_W    = 16;
    localparam int SLEN_W      = 6;

    // request opcodes
    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_APPEND = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_IGNORED    = 2'd1,
        ST_ZERO_LIMIT = 2'd2
    } t_status;

    // memory read address source
    typedef enum logic [1:0] {
        RD_NONE   = 2'd0,
        RD_OLDEST = 2'd1,
        RD_WALK   = 2'd2,
        RD_COPY   = 2'd3
    } t_rd_sel;

    // input request payload
    typedef struct packed {
        t_opcode               opcode;
        logic [7:0]            data_byte;
        logic [REQLEN_W-1:0]   record_length;
        logic [IDX_W-1:0]      record_index;
        logic [LIMIT_W-1:0]    out_limit;
    } t_in_item;

    // result payload
    typedef struct packed {
        t_status               status;
        logic [7:0]            out_byte;
        logic                  byte_valid;
        logic                  last;
        logic [SLEN_W-1:0]     stored_length;
        logic [REC_W-1:0]      records_held;
    } t_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic       req_load;
        t_rd_sel    rd_sel;
        logic       drop_upd;
        logic       hdr_hi;
        logic       hdr_lo;
        logic       append;
        logic       walk_init;
        logic       walk_step;
        logic       hdr_take;
        logic       emit_byte;
        logic       emit_single;
        t_status    single_status;
        logic       single_len;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_opcode    opcode;
        logic       rec_open;
        logic       need_drop;
        logic       limit_zero;
        logic       idx_bad;
        logic       at_target;
        logic       copy_zero;
        logic       copy_last;
        logic       out_free;
    } t_stat;

    // header length byte, clipped to the longest record
    function automatic logic [LEN_W-1:0] hdr_len(input logic [7:0] b);
        logic [LEN_W-1:0] r;
        if (int'(b) > MAX_LEN) begin
            r = LEN_W'(MAX_LEN);
        end else begin
            r = LEN_W'(b);
        end
        return r;
    endfunction

    // ring position plus a short step, wrapped
    function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] p,
                                                  input logic [7:0] inc);
        logic [POS_W:0] s;
        s = {1'b0, p} + (POS_W+1)'(inc);
        if (s >= (POS_W+1)'(RING_BYTES)) begin
            s = s - (POS_W+1)'(RING_BYTES);
        end
        return s[POS_W-1:0];
    endfunction

endpackage

/* rtl/variable_record_log_ring.sv */
// variable_record_log_ring: top level of the length-prefixed log record ring
//
// A 1024-byte ring holds log records, each a two-byte length header and up
// to 63 text bytes. Requests come in on i_in (valid/ready): begin reserves a
// record and drops the oldest ones until it fits, append writes one text
// byte, read copies a record picked by index from the oldest. Each request
// gives one result on o_out (valid/ready), or one result per copied byte for
// a read, the final one marked last.
// A begin checks and drops one oldest record at a time, then writes the two
// header bytes; a read walks the headers from the oldest to the target record,
// then reads and emits each copied byte in turn.
// Each header lookup and each copied byte is one read of the ring memory,
// which has a registered read, so header walks set the read latency.
// Results leave from an output register: a new request is taken while the
// previous result still waits, and a stalled receiver holds the sequencer
// only when it has the next result ready to load.
// Reset clears pointers, counts and the open-record flag; the ring contents
// need no clearing since only complete records are ever read.
module variable_record_log_ring (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vrlr_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vrlr_pkg::t_out_item o_out
);

    vrlr_pkg::t_cmd  w_cmd;
    vrlr_pkg::t_stat w_stat;

    // sequencer
    vrlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // memory, pointers and result register
    vrlr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* rtl/vrlr_ctrl.sv */
// vrlr_ctrl: sequencing state machine of the log record ring
module vrlr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vrlr_pkg::t_stat   i_stat,
    output vrlr_pkg::t_cmd    o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_DISPATCH  = 11'b000_0000_0010,
        S_DROP_CHK  = 11'b000_0000_0100,
        S_DROP_UPD  = 11'b000_0000_1000,
        S_HDR_HI    = 11'b000_0001_0000,
        S_HDR_LO    = 11'b000_0010_0000,
        S_WALK_RD   = 11'b000_0100_0000,
        S_WALK_UPD  = 11'b000_1000_0000,
        S_COPY_RD   = 11'b001_0000_0000,
        S_COPY_EMIT = 11'b010_0000_0000,
        S_RESP      = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    vrlr_pkg::t_status r_resp_status, n_resp_status;
    logic              r_resp_len, n_resp_len;

    // state and pending single response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_resp_status <= vrlr_pkg::ST_OK;
            r_resp_len    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_resp_status <= n_resp_status;
            r_resp_len    <= n_resp_len;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_resp_status = r_resp_status;
        n_resp_len    = r_resp_len;
        o_cmd         = '0;
        o_cmd.rd_sel  = vrlr_pkg::RD_NONE;
        o_cmd.single_status = r_resp_status;
        o_cmd.single_len    = r_resp_len;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_resp_status = vrlr_pkg::ST_IGNORED;
                n_resp_len    = 1'b0;
                n_state       = S_RESP;
                unique case (i_stat.opcode)
                    vrlr_pkg::OP_BEGIN: begin
                        if (!i_stat.rec_open) begin
                            n_state = S_DROP_CHK;
                        end
                    end
                    vrlr_pkg::OP_APPEND: begin
                        if (i_stat.rec_open) begin
                            o_cmd.append  = 1'b1;
                            n_resp_status = vrlr_pkg::ST_OK;
                        end
                    end
                    vrlr_pkg::OP_READ: begin
                        if (i_stat.limit_zero) begin
                            n_resp_status = vrlr_pkg::ST_ZERO_LIMIT;
                        end else if (!i_stat.idx_bad) begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_WALK_RD;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            // drop oldest records until the new one fits
            S_DROP_CHK: begin
                if (i_stat.need_drop) begin
                    o_cmd.rd_sel = vrlr_pkg::RD_OLDEST;
                    n_state      = S_DROP_UPD;
                end else begin
                    n_state = S_HDR_HI;
                end
            end
            S_DROP_UPD: begin
                o_cmd.drop_upd = 1'b1;
                n_state        = S_DROP_CHK;
            end
            S_HDR_HI: begin
                o_cmd.hdr_hi = 1'b1;
                n_state      = S_HDR_LO;
            end
            S_HDR_LO: begin
                o_cmd.hdr_lo  = 1'b1;
                n_resp_status = vrlr_pkg::ST_OK;
                n_resp_len    = 1'b0;
                n_state       = S_RESP;
            end
            // walk headers up to the requested record
            S_WALK_RD: begin
                o_cmd.rd_sel = vrlr_pkg::RD_WALK;
                n_state      = S_WALK_UPD;
            end
            S_WALK_UPD: begin
                if (i_stat.at_target) begin
                    o_cmd.hdr_take = 1'b1;
                    if (i_stat.copy_zero) begin
                        n_resp_status = vrlr_pkg::ST_OK;
                        n_resp_len    = 1'b1;
                        n_state       = S_RESP;
                    end else begin
                        n_state = S_COPY_RD;
                    end
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_WALK_RD;
                end
            end
            // stream record bytes
            S_COPY_RD: begin
                o_cmd.rd_sel = vrlr_pkg::RD_COPY;
                n_state      = S_COPY_EMIT;
            end
            S_COPY_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    n_state         = i_stat.copy_last ? S_IDLE : S_COPY_RD;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/vrlr_datapath.sv */
// vrlr_datapath: ring memory, pointers, counters and result register
module vrlr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vrlr_pkg::t_in_item  i_in,
    input  vrlr_pkg::t_cmd      i_cmd,
    output vrlr_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vrlr_pkg::t_out_item o_out
);

    // ring storage
    logic [7:0]                      r_mem [vrlr_pkg::RING_BYTES];
    logic [7:0]                      r_rd_data;

    // ring control state
    logic [vrlr_pkg::POS_W-1:0]      r_wr_pos;
    logic [vrlr_pkg::POS_W-1:0]      r_oldest;
    logic [vrlr_pkg::CNT_W-1:0]      r_used;
    logic [vrlr_pkg::REC_W-1:0]      r_records;
    logic [vrlr_pkg::LEN_W-1:0]      r_open_left;
    logic                            r_open;
    logic                            r_out_valid;

    // request and walk registers
    vrlr_pkg::t_in_item              r_req;
    logic [vrlr_pkg::LEN_W-1:0]      r_n;
    logic [vrlr_pkg::POS_W-1:0]      r_pos;
    logic [vrlr_pkg::IDX_W-1:0]      r_walk_cnt;
    logic [vrlr_pkg::LEN_W-1:0]      r_len;
    logic [vrlr_pkg::LEN_W-1:0]      r_left;
    vrlr_pkg::t_out_item             r_out;

    logic [vrlr_pkg::POS_W-1:0]      w_rd_addr;
    logic                            w_rd_en;
    logic                            w_wr_en;
    logic [7:0]                      w_wr_data;
    logic [vrlr_pkg::LEN_W-1:0]      w_hdr_len;
    logic [7:0]                      w_span;
    logic [vrlr_pkg::LIMIT_W-1:0]    w_lim_m1;
    logic [vrlr_pkg::LEN_W-1:0]      w_copy;
    logic [vrlr_pkg::LEN_W-1:0]      w_n_clip;
    logic [vrlr_pkg::CNT_W:0]        w_need;
    logic                            w_load_out;

    // clip requested length
    assign w_n_clip = (i_in.record_length > vrlr_pkg::REQLEN_W'(vrlr_pkg::MAX_LEN))
                    ? vrlr_pkg::LEN_W'(vrlr_pkg::MAX_LEN)
                    : vrlr_pkg::LEN_W'(i_in.record_length);

    // header just read and the span it covers
    assign w_hdr_len = vrlr_pkg::hdr_len(r_rd_data);
    assign w_span    = 8'(vrlr_pkg::HDR_BYTES) + 8'(w_hdr_len);

    // bytes copied for the target record
    assign w_lim_m1 = r_req.out_limit - vrlr_pkg::LIMIT_W'(1);
    assign w_copy   = (vrlr_pkg::LIMIT_W'(w_hdr_len) < w_lim_m1)
                    ? w_hdr_len : w_lim_m1[vrlr_pkg::LEN_W-1:0];

    // space needed for a new record
    assign w_need = (vrlr_pkg::CNT_W+1)'(r_used) + (vrlr_pkg::CNT_W+1)'(vrlr_pkg::HDR_BYTES)
                  + (vrlr_pkg::CNT_W+1)'(r_n);

    // status to controller
    always_comb begin
        o_stat.opcode     = r_req.opcode;
        o_stat.rec_open   = r_open;
        o_stat.need_drop  = (r_records != '0)
                          && (w_need > (vrlr_pkg::CNT_W+1)'(vrlr_pkg::RING_BYTES));
        o_stat.limit_zero = (r_req.out_limit == '0);
        o_stat.idx_bad    = (vrlr_pkg::REC_W'(r_req.record_index) >= r_records);
        o_stat.at_target  = (r_walk_cnt == r_req.record_index);
        o_stat.copy_zero  = (w_copy == '0);
        o_stat.copy_last  = (r_left == vrlr_pkg::LEN_W'(1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // memory read address
    always_comb begin
        case (i_cmd.rd_sel)
            vrlr_pkg::RD_OLDEST: w_rd_addr = vrlr_pkg::wrap_add(r_oldest, 8'd1);
            vrlr_pkg::RD_WALK:   w_rd_addr = vrlr_pkg::wrap_add(r_pos, 8'd1);
            default:             w_rd_addr = r_pos;
        endcase
    end
    assign w_rd_en = (i_cmd.rd_sel != vrlr_pkg::RD_NONE);

    // memory write: header high byte is always zero since lengths stay below 256
    assign w_wr_en   = i_cmd.hdr_hi || i_cmd.hdr_lo || i_cmd.append;
    assign w_wr_data = i_cmd.append ? r_req.data_byte
                     : (i_cmd.hdr_lo ? 8'(r_n) : 8'h00);

    // ring memory ports
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr_pos] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign w_load_out = i_cmd.emit_byte || i_cmd.emit_single;

    // ring control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos    <= '0;
            r_oldest    <= '0;
            r_used      <= '0;
            r_records   <= '0;
            r_open_left <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_wr_pos <= vrlr_pkg::wrap_add(r_wr_pos, 8'd1);
            end
            if (i_cmd.drop_upd) begin
                r_oldest  <= vrlr_pkg::wrap_add(r_oldest, w_span);
                r_used    <= (r_used >= vrlr_pkg::CNT_W'(w_span))
                           ? r_used - vrlr_pkg::CNT_W'(w_span) : '0;
                r_records <= r_records - vrlr_pkg::REC_W'(1);
            end else if (i_cmd.hdr_lo) begin
                r_used <= r_used + vrlr_pkg::CNT_W'(vrlr_pkg::HDR_BYTES)
                        + vrlr_pkg::CNT_W'(r_n);
                if (r_n == '0) begin
                    r_records <= r_records + vrlr_pkg::REC_W'(1);
                end else begin
                    r_open      <= 1'b1;
                    r_open_left <= r_n;
                end
            end else if (i_cmd.append) begin
                r_open_left <= r_open_left - vrlr_pkg::LEN_W'(1);
                if (r_open_left == vrlr_pkg::LEN_W'(1)) begin
                    r_open    <= 1'b0;
                    r_records <= r_records + vrlr_pkg::REC_W'(1);
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request, walk and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_in;
            r_n   <= w_n_clip;
        end
        if (i_cmd.walk_init) begin
            r_pos      <= r_oldest;
            r_walk_cnt <= '0;
        end else if (i_cmd.walk_step) begin
            r_pos      <= vrlr_pkg::wrap_add(r_pos, w_span);
            r_walk_cnt <= r_walk_cnt + vrlr_pkg::IDX_W'(1);
        end else if (i_cmd.hdr_take) begin
            r_pos  <= vrlr_pkg::wrap_add(r_pos, 8'(vrlr_pkg::HDR_BYTES));
            r_len  <= w_hdr_len;
            r_left <= w_copy;
        end else if (i_cmd.emit_byte) begin
            r_pos  <= vrlr_pkg::wrap_add(r_pos, 8'd1);
            r_left <= r_left - vrlr_pkg::LEN_W'(1);
        end
        if (i_cmd.emit_byte) begin
            r_out.status        <= vrlr_pkg::ST_OK;
            r_out.out_byte      <= r_rd_data;
            r_out.byte_valid    <= 1'b1;
            r_out.last          <= (r_left == vrlr_pkg::LEN_W'(1));
            r_out.stored_length <= vrlr_pkg::SLEN_W'(r_len);
            r_out.records_held  <= r_records;
        end else if (i_cmd.emit_single) begin
            r_out.status        <= i_cmd.single_status;
            r_out.out_byte      <= 8'h00;
            r_out.byte_valid    <= 1'b0;
            r_out.last          <= 1'b1;
            r_out.stored_length <= i_cmd.single_len ? vrlr_pkg::SLEN_W'(r_len) : '0;
            r_out.records_held  <= r_records;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/vrlr_checker.sv */
// vrlr_checker: port-level assertions for the log record ring and its bind
module vrlr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input vrlr_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input vrlr_pkg::t_out_item o_out
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // stalled result payload unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("result payload changed while stalled");

    // results without a byte always close their request
    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.byte_valid |-> o_out.last)
        else $error("byteless result not marked last");

    // error results carry no byte and no length
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != vrlr_pkg::ST_OK)
        |-> !o_out.byte_valid && (o_out.stored_length == '0) && o_out.last)
        else $error("error result has record data");

    // record count bounded by ring capacity
    a_rec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.records_held
                         <= vrlr_pkg::REC_W'(vrlr_pkg::RING_BYTES / vrlr_pkg::HDR_BYTES)))
        else $error("record count beyond ring capacity");

endmodule

bind variable_record_log_ring vrlr_checker u_vrlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
